@@ design/swsp_pkg.sv @@
// swsp_pkg: shared types and constants for the wav stream player
`timescale 1ns / 1ps
`default_nettype none

package swsp_pkg;

   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam logic [7:0]  TOKEN_START    = 8'hFE;
   localparam logic [7:0]  BUSY_BYTE      = 8'hFF;
   localparam logic [7:0]  SILENCE_BYTE   = 8'h80;
   localparam logic [9:0]  HDR_SKIP       = 10'd40;
   localparam logic [9:0]  HDR_END        = 10'd44;
   localparam logic [9:0]  SECTOR_END     = 10'(SECTOR_BYTES);
   localparam logic [5:0]  CMD_STOP       = 6'd12;
   localparam logic [5:0]  CMD_READ_MULTI = 6'd18;
   localparam logic [31:0] LEFT_UNKNOWN   = 32'hFFFF_FFFF;

   // request codes as they arrive on the input channel
   localparam logic [2:0] REQ_CARD   = 3'd0;
   localparam logic [2:0] REQ_START  = 3'd1;
   localparam logic [2:0] REQ_STOP   = 3'd2;
   localparam logic [2:0] REQ_PAUSE  = 3'd3;
   localparam logic [2:0] REQ_RESUME = 3'd4;
   localparam logic [2:0] REQ_TICK   = 3'd5;

   typedef enum logic [2:0] {
      OP_CARD,
      OP_START,
      OP_STOP,
      OP_PAUSE,
      OP_RESUME,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_PLAYING = 2'd1,
      ST_PAUSED  = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_TOKEN,
      PH_PAYLOAD,
      PH_CRC1,
      PH_CRC2
   } phase_type;

   typedef struct packed {
      op_type      op;
      logic        is_token;
      logic        is_busy;
      logic [7:0]  card_byte;
      logic [22:0] start_sector;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic        sample_valid;
      logic [7:0]  sample_value;
      logic [8:0]  bank_pos;
      logic        fill_silence;
      logic        bank_done;
      logic        cmd_valid;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_arg;
      logic [1:0]  player_status;
      logic [22:0] current_sector;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/swsp_req_if.sv @@
// swsp_req_if: input channel carrying control events and card bytes
`timescale 1ns / 1ps
`default_nettype none

interface swsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  card_byte;
   logic [22:0] start_sector;

   modport source (output valid, output req_type, output card_byte,
                   output start_sector, input ready);
   modport sink   (input valid, input req_type, input card_byte,
                   input start_sector, output ready);
endinterface

`default_nettype wire

@@ design/swsp_rsp_if.sv @@
// swsp_rsp_if: result channel carrying bank writes and card commands
`timescale 1ns / 1ps
`default_nettype none

interface swsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        sample_valid;
   logic [7:0]  sample_value;
   logic [8:0]  bank_pos;
   logic        fill_silence;
   logic        bank_done;
   logic        cmd_valid;
   logic [5:0]  cmd_index;
   logic [31:0] cmd_arg;
   logic [1:0]  player_status;
   logic [22:0] current_sector;
   logic        last;

   modport source (output valid, output sample_valid, output sample_value,
                   output bank_pos, output fill_silence, output bank_done,
                   output cmd_valid, output cmd_index, output cmd_arg,
                   output player_status, output current_sector, output last,
                   input ready);
   modport sink   (input valid, input sample_valid, input sample_value,
                   input bank_pos, input fill_silence, input bank_done,
                   input cmd_valid, input cmd_index, input cmd_arg,
                   input player_status, input current_sector, input last,
                   output ready);
endinterface

`default_nettype wire

@@ design/swsp_front.sv @@
// swsp_front: request decode and transaction queue toward the player core
`timescale 1ns / 1ps
`default_nettype none

module swsp_front (
   input  logic                  clock,
   input  logic                  reset,
   swsp_req_if.sink              req_chan,
   output swsp_pkg::queue_out_type q_head,
   input  logic                  q_pop
);
   import swsp_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [PTR_W:0]     count_ff;
   logic [PTR_W:0]     count_in;
   item_type           item;
   logic               push;

   // classify the incoming transaction
   always_comb begin
      item.card_byte    = req_chan.card_byte;
      item.start_sector = req_chan.start_sector;
      item.is_token     = (req_chan.card_byte == TOKEN_START);
      item.is_busy      = (req_chan.card_byte == BUSY_BYTE);
      unique case (req_chan.req_type)
         REQ_CARD:   item.op = OP_CARD;
         REQ_START:  item.op = OP_START;
         REQ_STOP:   item.op = OP_STOP;
         REQ_PAUSE:  item.op = OP_PAUSE;
         REQ_RESUME: item.op = OP_RESUME;
         REQ_TICK:   item.op = OP_TICK;
         default:    item.op = OP_NONE;
      endcase
   end

   assign req_chan.ready = (count_ff != DEPTH_CNT);
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = slot_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count above depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == DEPTH_CNT) |-> !req_chan.ready)
      else $error("full queue still ready");

endmodule

`default_nettype wire

@@ design/swsp_back.sv @@
// swsp_back: player state, sector framing and result register
`timescale 1ns / 1ps
`default_nettype none

module swsp_back #(
   parameter int unsigned BANK_SIZE = 262
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swsp_pkg::queue_out_type q_head,
   output logic                   q_pop,
   swsp_rsp_if.source             rsp_chan
);
   import swsp_pkg::*;

   localparam logic [9:0] BANK_LIMIT = 10'(BANK_SIZE);

   status_type  status_ff;
   status_type  status_in;
   logic [22:0] sector_ff;
   logic [22:0] sector_in;
   phase_type   phase_ff;
   phase_type   phase_in;
   logic [9:0]  offset_ff;
   logic [9:0]  offset_in;
   logic [8:0]  bank_ff;
   logic [8:0]  bank_in;
   logic [31:0] left_ff;
   logic [31:0] left_in;
   logic        hdr_ff;
   logic        hdr_in;

   rsp_type     out_ff;
   logic        out_vld_ff;
   rsp_type     second_ff;
   logic        second_vld_ff;

   rsp_type     r0;
   rsp_type     r1;
   logic        two;
   logic        advance;
   logic [9:0]  bank_inc;
   logic [9:0]  off_inc;
   logic [31:0] left_dec;
   logic [31:0] hdr_left;
   logic [1:0]  lane;
   item_type    it;

   assign it      = q_head.item;
   assign advance = !out_vld_ff || rsp_chan.ready;
   assign q_pop   = q_head.valid && advance && !second_vld_ff;

   always_comb begin
      status_in = status_ff;
      sector_in = sector_ff;
      phase_in  = phase_ff;
      offset_in = offset_ff;
      bank_in   = bank_ff;
      left_in   = left_ff;
      hdr_in    = hdr_ff;
      r0        = '0;
      r1        = '0;
      two       = 1'b0;
      bank_inc  = {1'b0, bank_ff} + 10'd1;
      off_inc   = offset_ff + 10'd1;
      left_dec  = left_ff - 32'd1;
      lane      = 2'(offset_ff - HDR_SKIP);
      hdr_left  = left_ff;
      if (offset_ff >= HDR_SKIP && offset_ff < HDR_END) begin
         hdr_left[{lane, 3'b000} +: 8] = it.card_byte;
      end

      if (q_pop) begin
         unique case (it.op)
            OP_CARD: begin
               if (status_ff == ST_PLAYING) begin
                  unique case (phase_ff)
                     PH_PAYLOAD: begin
                        if (hdr_ff) begin
                           left_in   = hdr_left;
                           offset_in = off_inc;
                           if (off_inc >= HDR_END) begin
                              hdr_in = 1'b0;
                              // empty file ends at once
                              if (hdr_left == '0) begin
                                 r0.fill_silence = 1'b1;
                                 r0.bank_pos     = bank_ff;
                                 r0.bank_done    = 1'b1;
                                 r0.cmd_valid    = 1'b1;
                                 r0.cmd_index    = CMD_STOP;
                                 status_in       = ST_STOPPED;
                                 phase_in        = PH_TOKEN;
                                 offset_in       = '0;
                                 bank_in         = '0;
                              end
                           end
                        end else begin
                           r0.sample_valid = 1'b1;
                           r0.sample_value = it.card_byte;
                           r0.bank_pos     = bank_ff;
                           left_in         = left_dec;
                           bank_in         = bank_inc[8:0];
                           offset_in       = off_inc;
                           if (left_dec == '0) begin
                              if (bank_inc >= BANK_LIMIT) begin
                                 r0.bank_done = 1'b1;
                                 r0.cmd_valid = 1'b1;
                                 r0.cmd_index = CMD_STOP;
                              end else begin
                                 two             = 1'b1;
                                 r1.fill_silence = 1'b1;
                                 r1.bank_pos     = bank_inc[8:0];
                                 r1.bank_done    = 1'b1;
                                 r1.cmd_valid    = 1'b1;
                                 r1.cmd_index    = CMD_STOP;
                              end
                              status_in = ST_STOPPED;
                              phase_in  = PH_TOKEN;
                              offset_in = '0;
                              bank_in   = '0;
                           end else begin
                              if (bank_inc >= BANK_LIMIT) begin
                                 r0.bank_done = 1'b1;
                                 bank_in      = '0;
                              end
                              if (off_inc >= SECTOR_END) begin
                                 phase_in = PH_CRC1;
                              end
                           end
                        end
                     end
                     PH_CRC1: phase_in = PH_CRC2;
                     PH_CRC2: begin
                        sector_in = sector_ff + 23'd1;
                        offset_in = '0;
                        phase_in  = PH_TOKEN;
                     end
                     PH_TOKEN: begin
                        if (it.is_token) begin
                           phase_in  = PH_PAYLOAD;
                           offset_in = '0;
                        end else if (!it.is_busy) begin
                           status_in = ST_ERROR;
                        end
                     end
                  endcase
               end
            end
            OP_START: begin
               if (status_ff == ST_PLAYING) begin
                  two          = 1'b1;
                  r0.cmd_valid = 1'b1;
                  r0.cmd_index = CMD_STOP;
                  r1.cmd_valid = 1'b1;
                  r1.cmd_index = CMD_READ_MULTI;
                  r1.cmd_arg   = {it.start_sector, 9'd0};
               end else begin
                  r0.cmd_valid = 1'b1;
                  r0.cmd_index = CMD_READ_MULTI;
                  r0.cmd_arg   = {it.start_sector, 9'd0};
               end
               sector_in = it.start_sector;
               phase_in  = PH_TOKEN;
               offset_in = '0;
               bank_in   = '0;
               left_in   = LEFT_UNKNOWN;
               hdr_in    = 1'b1;
               status_in = ST_PLAYING;
            end
            OP_STOP: begin
               if (status_ff == ST_PLAYING) begin
                  r0.cmd_valid = 1'b1;
                  r0.cmd_index = CMD_STOP;
               end
               status_in = ST_STOPPED;
            end
            OP_PAUSE: begin
               if (status_ff == ST_PLAYING) begin
                  r0.cmd_valid = 1'b1;
                  r0.cmd_index = CMD_STOP;
                  status_in    = ST_PAUSED;
               end
            end
            OP_RESUME: begin
               if (status_ff == ST_PAUSED) begin
                  r0.cmd_valid = 1'b1;
                  r0.cmd_index = CMD_READ_MULTI;
                  r0.cmd_arg   = {sector_ff, 9'd0};
                  phase_in     = PH_TOKEN;
                  offset_in    = '0;
                  bank_in      = '0;
                  status_in    = ST_PLAYING;
               end
            end
            OP_TICK: begin
               if (status_ff != ST_PLAYING) begin
                  r0.fill_silence = 1'b1;
                  r0.bank_done    = 1'b1;
               end
            end
            default: ;
         endcase
      end

      r0.player_status  = status_in;
      r0.current_sector = sector_in;
      r0.last           = !two;
      r1.player_status  = status_in;
      r1.current_sector = sector_in;
      r1.last           = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= ST_STOPPED;
         sector_ff     <= '0;
         phase_ff      <= PH_TOKEN;
         offset_ff     <= '0;
         bank_ff       <= '0;
         left_ff       <= LEFT_UNKNOWN;
         hdr_ff        <= 1'b1;
         out_vld_ff    <= 1'b0;
         second_vld_ff <= 1'b0;
      end else begin
         status_ff <= status_in;
         sector_ff <= sector_in;
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         bank_ff   <= bank_in;
         left_ff   <= left_in;
         hdr_ff    <= hdr_in;
         if (advance) begin
            if (second_vld_ff) begin
               out_vld_ff    <= 1'b1;
               second_vld_ff <= 1'b0;
            end else begin
               out_vld_ff    <= q_pop;
               second_vld_ff <= q_pop && two;
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (second_vld_ff) begin
            out_ff <= second_ff;
         end else if (q_pop) begin
            out_ff    <= r0;
            second_ff <= r1;
         end
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.sample_valid   = out_ff.sample_valid;
   assign rsp_chan.sample_value   = out_ff.sample_value;
   assign rsp_chan.bank_pos       = out_ff.bank_pos;
   assign rsp_chan.fill_silence   = out_ff.fill_silence;
   assign rsp_chan.bank_done      = out_ff.bank_done;
   assign rsp_chan.cmd_valid      = out_ff.cmd_valid;
   assign rsp_chan.cmd_index      = out_ff.cmd_index;
   assign rsp_chan.cmd_arg        = out_ff.cmd_arg;
   assign rsp_chan.player_status  = out_ff.player_status;
   assign rsp_chan.current_sector = out_ff.current_sector;
   assign rsp_chan.last           = out_ff.last;

   a_second_behind_first: assert property (@(posedge clock) disable iff (reset)
      second_vld_ff |-> out_vld_ff)
      else $error("second result pending without a first");

   a_bank_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, bank_ff} < BANK_LIMIT)
      else $error("bank index past bank size");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= SECTOR_END)
      else $error("sector offset past sector end");

   a_start_plays: assert property (@(posedge clock) disable iff (reset)
      q_pop && it.op == OP_START |=> status_ff == ST_PLAYING)
      else $error("start did not enter playing");

endmodule

`default_nettype wire

@@ design/sd_wav_stream_player.sv @@
// sd_wav_stream_player: top level of the sd card wav streaming player
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock on req_chan (control event or card byte)
// and returns its results on rsp_chan through a registered output stage.
// Most transactions give one result and sustain one per cycle while rsp_chan
// is ready; a start while playing and the final sample of a file that leaves
// the bank partly filled give two results, and no new transaction is taken
// until the second is in the output register. A four-entry queue sits between
// request decode and the player core, so the input keeps accepting while the
// output is stalled until that queue is full.

module sd_wav_stream_player #(
   parameter int unsigned BANK_SIZE = 262
) (
   input  logic       clock,
   input  logic       reset,
   swsp_req_if.sink   req_chan,
   swsp_rsp_if.source rsp_chan
);
   import swsp_pkg::*;

   queue_out_type q_head;
   logic          q_pop;

   swsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   swsp_back #(
      .BANK_SIZE (BANK_SIZE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/sv/sd_wav_stream_player_chk.sv @@
// sd_wav_stream_player_chk: predicts and checks the player's result transactions
`timescale 1ns / 1ps

module sd_wav_stream_player_chk #(
   parameter int unsigned BANK_SIZE = 262
) (
   input  logic clock,
   input  logic reset,
   swsp_req_if  req_mon,
   swsp_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   results_seen,
   output int   samples_seen,
   output int   commands_seen
);
   import swsp_pkg::*;

   status_type  status;
   logic [22:0] sector;
   phase_type   phase;
   logic [9:0]  offset;
   logic [9:0]  bank_idx;
   logic [31:0] samples_left;
   logic        header_pending;

   rsp_type     outcome [2];
   int          n_out;
   rsp_type     awaited_results [$];

   function automatic string show(rsp_type r);
      return {$sformatf("sv=%0d val=%02h pos=%0d fill=%0d done=%0d cmd=%0d/%0d ",
                        r.sample_valid, r.sample_value, r.bank_pos, r.fill_silence,
                        r.bank_done, r.cmd_valid, r.cmd_index),
              $sformatf("arg=%08h st=%0d sec=%06h last=%0d",
                        r.cmd_arg, r.player_status, r.current_sector, r.last)};
   endfunction

   task automatic set_command(input int slot, input logic [5:0] index,
                              input logic [31:0] arg);
      outcome[slot].cmd_valid = 1'b1;
      outcome[slot].cmd_index = index;
      outcome[slot].cmd_arg   = arg;
   endtask

   task automatic rewind_frame();
      phase    = PH_TOKEN;
      offset   = '0;
      bank_idx = '0;
   endtask

   // end of file: pad the bank with silence unless it just filled up
   task automatic close_file();
      int k;
      k = n_out;
      if (bank_idx >= BANK_SIZE && n_out > 0) begin
         k = n_out - 1;
      end else begin
         outcome[k].fill_silence = 1'b1;
         outcome[k].bank_pos     = bank_idx[8:0];
         n_out++;
      end
      outcome[k].bank_done = 1'b1;
      set_command(k, CMD_STOP, '0);
      status = ST_STOPPED;
      rewind_frame();
   endtask

   task automatic advance_player(input logic [2:0] kind, input logic [7:0] data,
                                 input logic [22:0] first_sector);
      outcome[0] = '0;
      outcome[1] = '0;
      n_out = 1;
      case (kind)
         REQ_CARD: if (status == ST_PLAYING) begin
            case (phase)
               PH_PAYLOAD: if (header_pending) begin
                  if (offset >= HDR_SKIP && offset < HDR_END)
                     samples_left[8 * int'(offset - HDR_SKIP) +: 8] = data;
                  offset++;
                  if (offset >= HDR_END) begin
                     header_pending = 1'b0;
                     if (samples_left == 0) begin
                        n_out = 0;
                        close_file();
                     end
                  end
               end else begin
                  outcome[0].sample_valid = 1'b1;
                  outcome[0].sample_value = data;
                  outcome[0].bank_pos     = bank_idx[8:0];
                  samples_left--;
                  bank_idx++;
                  offset++;
                  if (samples_left == 0) begin
                     close_file();
                  end else begin
                     if (bank_idx >= BANK_SIZE) begin
                        outcome[0].bank_done = 1'b1;
                        bank_idx = '0;
                     end
                     if (offset >= SECTOR_END) phase = PH_CRC1;
                  end
               end
               PH_CRC1: phase = PH_CRC2;
               PH_CRC2: begin
                  sector++;
                  offset = '0;
                  phase  = PH_TOKEN;
               end
               default: begin
                  if (data == TOKEN_START) begin
                     phase  = PH_PAYLOAD;
                     offset = '0;
                  end else if (data != BUSY_BYTE) begin
                     status = ST_ERROR;
                  end
               end
            endcase
         end
         REQ_START: begin
            n_out = 0;
            if (status == ST_PLAYING) begin
               set_command(0, CMD_STOP, '0);
               n_out = 1;
            end
            sector = first_sector;
            set_command(n_out, CMD_READ_MULTI, {first_sector, 9'd0});
            n_out++;
            rewind_frame();
            samples_left   = LEFT_UNKNOWN;
            header_pending = 1'b1;
            status         = ST_PLAYING;
         end
         REQ_STOP: begin
            if (status == ST_PLAYING) set_command(0, CMD_STOP, '0);
            status = ST_STOPPED;
         end
         REQ_PAUSE: if (status == ST_PLAYING) begin
            set_command(0, CMD_STOP, '0);
            status = ST_PAUSED;
         end
         REQ_RESUME: if (status == ST_PAUSED) begin
            set_command(0, CMD_READ_MULTI, {sector, 9'd0});
            rewind_frame();
            status = ST_PLAYING;
         end
         REQ_TICK: if (status != ST_PLAYING) begin
            outcome[0].fill_silence = 1'b1;
            outcome[0].bank_done    = 1'b1;
         end
         default: ;
      endcase
      for (int k = 0; k < n_out; k++) begin
         outcome[k].player_status  = status;
         outcome[k].current_sector = sector;
         outcome[k].last           = (k == n_out - 1);
         awaited_results.push_back(outcome[k]);
      end
   endtask

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch (%s)\n   expected %s\n   actual   %s",
                  $time, what, show(want), show(got));
   endtask

   task automatic check_result();
      rsp_type got;
      rsp_type want;
      string   diffs;
      got = {rsp_mon.sample_valid, rsp_mon.sample_value, rsp_mon.bank_pos,
             rsp_mon.fill_silence, rsp_mon.bank_done, rsp_mon.cmd_valid,
             rsp_mon.cmd_index, rsp_mon.cmd_arg, rsp_mon.player_status,
             rsp_mon.current_sector, rsp_mon.last};
      diffs = "";
      results_seen++;
      if (got.sample_valid) samples_seen++;
      if (got.cmd_valid) commands_seen++;
      if (awaited_results.size() == 0) begin
         log_mismatch("unexpected transaction", '0, got);
      end else begin
         want = awaited_results.pop_front();
         if (got.sample_valid !== want.sample_valid) diffs = {diffs, " sample_valid"};
         if (got.sample_value !== want.sample_value) diffs = {diffs, " sample_value"};
         if (got.bank_pos !== want.bank_pos) diffs = {diffs, " bank_pos"};
         if (got.fill_silence !== want.fill_silence) diffs = {diffs, " fill_silence"};
         if (got.bank_done !== want.bank_done) diffs = {diffs, " bank_done"};
         if (got.cmd_valid !== want.cmd_valid) diffs = {diffs, " cmd_valid"};
         if (got.cmd_index !== want.cmd_index) diffs = {diffs, " cmd_index"};
         if (got.cmd_arg !== want.cmd_arg) diffs = {diffs, " cmd_arg"};
         if (got.player_status !== want.player_status) diffs = {diffs, " player_status"};
         if (got.current_sector !== want.current_sector) diffs = {diffs, " current_sector"};
         if (got.last !== want.last) diffs = {diffs, " last"};
         if (diffs != "") log_mismatch({"field", diffs}, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         status         = ST_STOPPED;
         sector         = '0;
         phase          = PH_TOKEN;
         offset         = '0;
         bank_idx       = '0;
         samples_left   = LEFT_UNKNOWN;
         header_pending = 1'b1;
         awaited_results.delete();
         mismatches     = 0;
         results_seen   = 0;
         samples_seen   = 0;
         commands_seen  = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            advance_player(req_mon.req_type, req_mon.card_byte, req_mon.start_sector);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      outstanding = awaited_results.size();
   end

endmodule

@@ tb/sv/sd_wav_stream_player_tb.sv @@
// sd_wav_stream_player_tb: stimulus, handshake pacing and verdict for the wav player
`timescale 1ns / 1ps

module sd_wav_stream_player_tb;
   import swsp_pkg::*;

   localparam int unsigned BANK_SIZE = 262;
   localparam int ITEM_TARGET = 1400;
   localparam int IDLE_LIMIT  = 1000;
   localparam int MAX_WAIT    = 14;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   results_seen;
   int   samples_seen;
   int   commands_seen;
   int   items_sent;
   int   files_played;
   int   idle_cycles;
   bit   send_burst;
   bit   take_burst;

   swsp_req_if req_chan ();
   swsp_rsp_if rsp_chan ();

   sd_wav_stream_player #(
      .BANK_SIZE (BANK_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sd_wav_stream_player_chk #(
      .BANK_SIZE (BANK_SIZE)
   ) u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .samples_seen  (samples_seen),
      .commands_seen (commands_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("sd_wav_stream_player_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send(input logic [2:0] kind, input logic [7:0] data,
                       input logic [22:0] first_sector);
      int gap;
      if ($urandom_range(0, 99) < 3) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= kind;
      req_chan.card_byte    <= data;
      req_chan.start_sector <= first_sector;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // card side of a multi-block read: busy bytes, token, payload, crc per sector
   task automatic play_file(input logic [22:0] first_sector, input logic [31:0] length,
                            input int budget);
      int         total;
      int         pos;
      int         sector_base;
      int         pick;
      bit         rewind;
      bit         rewound;
      logic [7:0] data;
      total   = int'(HDR_END) + ((length < budget) ? int'(length) : budget);
      pos     = 0;
      rewound = 1'b0;
      send(REQ_START, 8'($urandom), first_sector);
      while (pos < total) begin
         sector_base = pos;
         rewind      = 1'b0;
         repeat ($urandom_range(0, 2)) send(REQ_CARD, BUSY_BYTE, 23'($urandom));
         send(REQ_CARD, TOKEN_START, 23'($urandom));
         while (!rewind && pos < total && pos - sector_base < SECTOR_BYTES) begin
            if (pos >= int'(HDR_SKIP) && pos < int'(HDR_END))
               data = length[8 * (pos - int'(HDR_SKIP)) +: 8];
            else
               data = 8'($urandom);
            send(REQ_CARD, data, 23'($urandom));
            pos++;
            pick = $urandom_range(0, 1999);
            if (pick < 6) begin
               send(REQ_TICK, 8'($urandom), 23'($urandom));
            end else if (pick < 9) begin
               send(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 8'($urandom),
                    23'($urandom));
            end else if (pick == 9 && !rewound && pos < total) begin
               // pause and resume: the card restarts the current sector
               send(REQ_PAUSE, 8'($urandom), 23'($urandom));
               send(REQ_RESUME, 8'($urandom), 23'($urandom));
               rewind  = 1'b1;
               rewound = 1'b1;
               pos     = sector_base;
            end
         end
         if (!rewind && pos - sector_base == SECTOR_BYTES) begin
            send(REQ_CARD, 8'($urandom), 23'($urandom));
            send(REQ_CARD, 8'($urandom), 23'($urandom));
         end
      end
      files_played++;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_CARD;
      req_chan.card_byte    <= '0;
      req_chan.start_sector <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single events in every player status
      send(REQ_TICK, 8'h00, 23'h000000);
      send(REQ_CARD, TOKEN_START, 23'h7FFFFF);
      send(REQ_PAUSE, 8'hFF, 23'h000000);
      send(REQ_RESUME, 8'h00, 23'h7FFFFF);
      send(REQ_STOP, 8'hFF, 23'h000000);
      send(REQ_UNUSED_LO, 8'h00, 23'h7FFFFF);
      send(REQ_UNUSED_HI, 8'hFF, 23'h7FFFFF);
      send(REQ_START, 8'h00, 23'h000000);
      send(REQ_TICK, 8'h00, 23'h000000);
      send(REQ_CARD, BUSY_BYTE, 23'h000000);
      send(REQ_CARD, 8'h00, 23'h000000);
      send(REQ_TICK, 8'h00, 23'h000000);
      send(REQ_CARD, TOKEN_START, 23'h000000);
      send(REQ_STOP, 8'h00, 23'h000000);
      send(REQ_START, 8'hFF, 23'h7FFFFF);
      send(REQ_START, 8'h55, 23'h2AAAAA);
      send(REQ_PAUSE, 8'h00, 23'h000000);
      send(REQ_CARD, TOKEN_START, 23'h000000);
      send(REQ_TICK, 8'h00, 23'h000000);
      send(REQ_PAUSE, 8'h00, 23'h000000);
      send(REQ_RESUME, 8'h00, 23'h000000);
      send(REQ_CARD, TOKEN_START, 23'h000000);
      send(REQ_CARD, 8'hFF, 23'h000000);
      send(REQ_STOP, 8'h00, 23'h000000);
      send(REQ_START, 8'hAA, 23'h555555);
      send(REQ_CARD, 8'h7F, 23'h000000);
      hold_until_drained();

      // two full banks across the last sector and its wrap to zero
      play_file(23'h7FFFFF, 32'd524, 524);
      // empty file
      play_file(23'($urandom), 32'd0, 0);
      hold_until_drained();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 70) begin
            logic [22:0] first_sector;
            logic [31:0] length;
            int          budget;
            case ($urandom_range(0, 3))
               0, 1:    first_sector = 23'($urandom);
               2:       first_sector = 23'h7FFFFF - 23'($urandom_range(0, 2));
               default: first_sector = 23'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 19))
               0, 1:    length = '0;
               2, 3, 4: length = $urandom;
               5:       length = 32'($urandom_range(BANK_SIZE - 12, BANK_SIZE + 18));
               default: length = 32'($urandom_range(1, 40));
            endcase
            budget = (length > 32'd300) ? $urandom_range(0, 40) : int'(length);
            if ($urandom_range(0, 9) == 0 && budget > 0) budget = $urandom_range(0, budget - 1);
            play_file(first_sector, length, budget);
            if (length > budget) begin
               case ($urandom_range(0, 3))
                  0: send(REQ_STOP, 8'($urandom), 23'($urandom));
                  1: send(REQ_PAUSE, 8'($urandom), 23'($urandom));
                  2: begin
                     send(REQ_PAUSE, 8'($urandom), 23'($urandom));
                     send(REQ_RESUME, 8'($urandom), 23'($urandom));
                     send(REQ_CARD, 8'($urandom_range(0, 8'hFD)), 23'($urandom));
                  end
                  default: ;
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 6))
               send(3'($urandom_range(REQ_CARD, REQ_UNUSED_HI)), 8'($urandom),
                    23'($urandom));
         end
         if (files_played % 8 == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (20) @(negedge clock);
      $display("run covered %0d requests including %0d file reads", items_sent, files_played);
      $display("%0d results checked: %0d bank samples, %0d card commands, %0d mismatches",
               results_seen, samples_seen, commands_seen, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("sd_wav_stream_player_tb: PASS");
      end else begin
         $display("sd_wav_stream_player_tb: FAIL");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 99) < 3) take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(negedge clock); while (!rsp_chan.valid);
         @(posedge clock);
      end
   end

endmodule
